// ===== hw/rtl/key_value_table_engine_unit_defines.svh =====
// assertion macros for the key-value table engine checker
// depends on nothing; the using scope provides aclk and aresetn
`ifndef KEY_VALUE_TABLE_ENGINE_UNIT_DEFINES_SVH
`define KEY_VALUE_TABLE_ENGINE_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define KVTE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("kvte assertion failed");

// antecedent implies consequent in the next cycle
`define KVTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("kvte assertion failed");

`endif

// ===== hw/rtl/kvte_pkg.sv =====
// shared types, codes and helpers of the key-value table engine
// depends on nothing
package kvte_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int TEXT_BYTES  = 8;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_GET    = 3'd1,
        OP_DELETE = 3'd2,
        OP_EXIST  = 3'd3,
        OP_MODIFY = 3'd4,
        OP_COPY   = 3'd5
    } op_code_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_PRESENT = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] key;
        logic signed [31:0] new_key;
        logic [63:0]        text;
        logic signed [31:0] number;
        logic [63:0]        real_bits;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [63:0]        text_out;
        logic signed [31:0] number_out;
        logic [63:0]        real_bits_out;
    } rsp_t;

    // value part of one table entry
    typedef struct packed {
        logic [63:0]        text;
        logic signed [31:0] number;
        logic [63:0]        real_bits;
    } entry_data_t;

    // keep the string up to its first zero byte, within TEXT_BYTES
    function automatic logic [63:0] clean_text(input logic [63:0] t);
        logic [63:0] r;
        logic        live;
        r    = '0;
        live = 1'b1;
        for (int b = 0; b < 8; b++) begin
            if (b >= TEXT_BYTES || t[8*b +: 8] == 8'd0) begin
                live = 1'b0;
            end
            if (live) begin
                r[8*b +: 8] = t[8*b +: 8];
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/key_value_table_engine_unit.sv =====
// top level of the key-value table engine: sequencer, key and data memories
// depends on kvte_pkg
//
// A table of up to TABLE_DEPTH entries, each a unique signed 32-bit key with
// a text word, an integer and a raw 64-bit real. Each request (insert, get,
// delete, exist, modify, copy) returns exactly one response with a status and
// read data; read data is zero except for a get that finds its key. A new
// entry takes the lowest free slot. Reset empties the table at once: only the
// valid bits are cleared, the memories need no clearing pass. Requests are
// handled one at a time. Each request scans all keys through the single read
// port of the key memory, one entry per cycle; get and a successful copy then
// read the data memory once more before the response. A new request is
// accepted in the cycle after the previous response is handed to the output
// register, so a response may still wait on m_ready while the next request
// is scanned.
module key_value_table_engine_unit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  kvte_pkg::req_t s_req,
    output logic           m_valid,
    input  logic           m_ready,
    output kvte_pkg::rsp_t m_rsp
);
    import kvte_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_LAST   = 6'b000100,
        S_DECIDE = 6'b001000,
        S_RDATA  = 6'b010000,
        S_RESP   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // request held for the whole operation
    req_t req_reg;

    // key scan
    logic [IDX_W-1:0] scan_addr_reg;
    logic             cmp_en_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic [31:0]      key_rd_reg;

    // scan results
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic             nhit_reg;
    logic             free_reg;
    logic [IDX_W-1:0] free_idx_reg;

    // valid bits live in flops so reset empties the table at once
    logic [TABLE_DEPTH-1:0] valid_reg;

    // memories
    logic [31:0]  key_mem  [TABLE_DEPTH];
    entry_data_t  data_mem [TABLE_DEPTH];
    entry_data_t  data_rd_reg;

    // response path
    rsp_t rsp_pend_reg;
    logic m_valid_reg;
    rsp_t m_rsp_reg;

    // memory and table update controls
    logic             key_wr_en;
    logic [IDX_W-1:0] key_wr_addr;
    logic [31:0]      key_wr_data;
    logic             data_rd_en;
    logic [IDX_W-1:0] data_rd_addr;
    logic             data_wr_en;
    logic [IDX_W-1:0] data_wr_addr;
    entry_data_t      data_wr_data;
    logic             valid_set;
    logic             valid_clr;
    logic [IDX_W-1:0] valid_idx;
    logic             rsp_load;
    rsp_t             rsp_next;

    logic accept;
    logic out_free;
    logic key_match;
    logic nkey_match;
    logic slot_free;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_rsp    = m_rsp_reg;

    // compare of the key read in the previous cycle
    assign key_match  = valid_reg[cmp_idx_reg] && (key_rd_reg == req_reg.key);
    assign nkey_match = valid_reg[cmp_idx_reg] && (key_rd_reg == req_reg.new_key);
    assign slot_free  = !valid_reg[cmp_idx_reg];

    // decide and finish the operation once the scan is complete
    always_comb begin
        state_next   = state_reg;
        key_wr_en    = 1'b0;
        key_wr_addr  = free_idx_reg;
        key_wr_data  = req_reg.key;
        data_rd_en   = 1'b0;
        data_rd_addr = hit_idx_reg;
        data_wr_en   = 1'b0;
        data_wr_addr = free_idx_reg;
        data_wr_data = '{text: clean_text(req_reg.text), number: req_reg.number,
                         real_bits: req_reg.real_bits};
        valid_set    = 1'b0;
        valid_clr    = 1'b0;
        valid_idx    = free_idx_reg;
        rsp_load     = 1'b0;
        rsp_next     = '0;
        rsp_next.status = ST_MISSING;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_addr_reg == LAST_IDX) begin
                    state_next = S_LAST;
                end
            end
            S_LAST: begin
                // compare of the last entry lands at the end of this cycle
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                rsp_load   = 1'b1;
                state_next = S_RESP;
                case (op_code_t'(req_reg.op))
                    OP_INSERT: begin
                        if (hit_reg) begin
                            rsp_next.status = ST_PRESENT;
                        end else if (!free_reg) begin
                            rsp_next.status = ST_FULL;
                        end else begin
                            key_wr_en       = 1'b1;
                            data_wr_en      = 1'b1;
                            valid_set       = 1'b1;
                            rsp_next.status = ST_OK;
                        end
                    end
                    OP_GET: begin
                        if (hit_reg) begin
                            // fetch the entry's values first
                            data_rd_en = 1'b1;
                            rsp_load   = 1'b0;
                            state_next = S_RDATA;
                        end
                    end
                    OP_DELETE: begin
                        if (hit_reg) begin
                            valid_clr       = 1'b1;
                            valid_idx       = hit_idx_reg;
                            rsp_next.status = ST_OK;
                        end
                    end
                    OP_EXIST: begin
                        if (hit_reg) begin
                            rsp_next.status = ST_OK;
                        end
                    end
                    OP_MODIFY: begin
                        if (hit_reg) begin
                            data_wr_en      = 1'b1;
                            data_wr_addr    = hit_idx_reg;
                            rsp_next.status = ST_OK;
                        end
                    end
                    OP_COPY: begin
                        // destination present wins, also for a copy onto itself
                        if (nhit_reg) begin
                            rsp_next.status = ST_PRESENT;
                        end else if (!hit_reg) begin
                            rsp_next.status = ST_MISSING;
                        end else if (!free_reg) begin
                            rsp_next.status = ST_FULL;
                        end else begin
                            data_rd_en = 1'b1;
                            rsp_load   = 1'b0;
                            state_next = S_RDATA;
                        end
                    end
                    default: begin
                        rsp_next.status = ST_MISSING;
                    end
                endcase
            end
            S_RDATA: begin
                rsp_load        = 1'b1;
                state_next      = S_RESP;
                rsp_next.status = ST_OK;
                if (op_code_t'(req_reg.op) == OP_GET) begin
                    rsp_next.text_out      = data_rd_reg.text;
                    rsp_next.number_out    = data_rd_reg.number;
                    rsp_next.real_bits_out = data_rd_reg.real_bits;
                end else begin
                    // copy: new key gets the source entry's values
                    key_wr_en    = 1'b1;
                    key_wr_data  = req_reg.new_key;
                    data_wr_en   = 1'b1;
                    data_wr_data = data_rd_reg;
                    valid_set    = 1'b1;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer and table control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            cmp_en_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cmp_en_reg <= (state_reg == S_SCAN);
            if (valid_set) begin
                valid_reg[valid_idx] <= 1'b1;
            end
            if (valid_clr) begin
                valid_reg[valid_idx] <= 1'b0;
            end
            // a new response replaces one taken in the same cycle
            if (state_reg == S_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request, scan results and response payload
    always_ff @(posedge aclk) begin
        cmp_idx_reg <= scan_addr_reg;
        if (accept) begin
            req_reg       <= s_req;
            scan_addr_reg <= '0;
            hit_reg       <= 1'b0;
            nhit_reg      <= 1'b0;
            free_reg      <= 1'b0;
        end else begin
            if (state_reg == S_SCAN && scan_addr_reg != LAST_IDX) begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
            end
            if (cmp_en_reg) begin
                // ascending scan: first hit and lowest free slot
                if (key_match && !hit_reg) begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= cmp_idx_reg;
                end
                if (nkey_match) begin
                    nhit_reg <= 1'b1;
                end
                if (slot_free && !free_reg) begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= cmp_idx_reg;
                end
            end
        end
        if (rsp_load) begin
            rsp_pend_reg <= rsp_next;
        end
        if (state_reg == S_RESP && out_free) begin
            m_rsp_reg <= rsp_pend_reg;
        end
    end

    // key memory, one read port used by the scan
    always_ff @(posedge aclk) begin
        if (state_reg == S_SCAN) begin
            key_rd_reg <= key_mem[scan_addr_reg];
        end
        if (key_wr_en) begin
            key_mem[key_wr_addr] <= key_wr_data;
        end
    end

    // data memory, values of each entry
    always_ff @(posedge aclk) begin
        if (data_rd_en) begin
            data_rd_reg <= data_mem[data_rd_addr];
        end
        if (data_wr_en) begin
            data_mem[data_wr_addr] <= data_wr_data;
        end
    end

endmodule

// ===== hw/rtl/kvte_checker.sv =====
// port-level checks of the key-value table engine, bound to its top level
// depends on kvte_pkg and key_value_table_engine_unit_defines.svh
`include "key_value_table_engine_unit_defines.svh"

module kvte_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input kvte_pkg::req_t s_req,
    input logic           m_valid,
    input logic           m_ready,
    input kvte_pkg::rsp_t m_rsp
);
    import kvte_pkg::*;

    logic no_data;

    assign no_data = (m_rsp.text_out == '0) && (m_rsp.number_out == '0) &&
                     (m_rsp.real_bits_out == '0);

    // a stalled response holds
    `KVTE_ASSERT_NEXT(a_rsp_hold, m_valid && !m_ready, m_valid && $stable(m_rsp))
    // a waiting request holds
    `KVTE_ASSERT_NEXT(a_req_hold, s_valid && !s_ready, s_valid && $stable(s_req))
    // one request in work at a time
    `KVTE_ASSERT_NEXT(a_one_req, s_valid && s_ready, !s_ready)
    // only a successful request can carry read data
    `KVTE_ASSERT_NOW(a_fail_no_data, m_valid && (m_rsp.status != ST_OK), no_data)

endmodule

bind key_value_table_engine_unit kvte_checker u_kvte_checker (.*);
